// File: design/gha_pkg.sv
`timescale 1ns / 1ps
// shared constants for the generational handle allocator
// no dependencies; used by generational_handle_allocator_core
package gha_pkg;

	localparam int IDX_W = 8;
	localparam int GEN_W = 16;
	localparam int SLOTS = 2 ** IDX_W;
	localparam int CNT_W = IDX_W + 1;
	localparam int FQ_W = GEN_W + IDX_W;
	localparam int TBL_W = GEN_W + 1;

	localparam int CMD_W = 2;
	localparam int STATUS_W = 2;
	localparam int IN_DATA_W = 8 * ((IDX_W + GEN_W + 7) / 8);
	localparam int OUT_DATA_W = 8 * ((IDX_W + GEN_W + 7) / 8);
	localparam int OUT_USER_W = STATUS_W + 1;

	localparam logic [CMD_W-1:0] CMD_CREATE = 2'd0;
	localparam logic [CMD_W-1:0] CMD_DESTROY = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CHECK = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
	localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NO_SLOT = 2'd2;

endpackage

// File: design/gha_ram.sv
`timescale 1ns / 1ps
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module gha_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: design/generational_handle_allocator_core.sv
`timescale 1ns / 1ps
// generational handle allocator: create, destroy and check of slot handles
// depends on gha_pkg and gha_ram (generation table with live bit, free slot queue)
//
// channel   dir  payload                                        handshake
// s_*       in   tuser: command; tdata: slot_index, handle_gen  tvalid/tready
// m_*       out  tuser: status, handle_live; tdata: index, gen  tvalid/tready
//
// one command per cycle sustained while results are taken; each command passes the s1
// stage and the output register; s1 uses the registered read of the generation table
// and the queue ram, with write forwarding from the command ahead
// reset clears queue pointers and the fresh slot counter; slots at or above the counter
// read as unused and a slot is cleared when first granted, so no ram clearing
// a stalled result holds the stage behind it and s_tready drops only then
module generational_handle_allocator_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// [7:0] slot_index, [23:8] handle_generation
	input  logic [gha_pkg::IN_DATA_W-1:0] s_tdata,
	// [1:0] command
	input  logic [gha_pkg::CMD_W-1:0]     s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// [7:0] result_index, [23:8] result_generation
	output logic [gha_pkg::OUT_DATA_W-1:0] m_tdata,
	// [1:0] status, [2] handle_live
	output logic [gha_pkg::OUT_USER_W-1:0] m_tuser
);

	import gha_pkg::*;

	logic                s_accept;
	logic [IDX_W-1:0]    s_idx;
	logic [GEN_W-1:0]    s_gen;

	logic                valid_s1;
	logic [CMD_W-1:0]    cmd_s1;
	logic [IDX_W-1:0]    idx_s1;
	logic [GEN_W-1:0]    gen_s1;
	logic                gen_fwd_s1;
	logic [TBL_W-1:0]    gen_fwd_data_s1;
	logic                fq_fwd_s1;
	logic [FQ_W-1:0]     fq_fwd_data_s1;
	logic                fire_s1;

	logic [IDX_W-1:0]    free_head_q;
	logic [IDX_W-1:0]    free_tail_q;
	logic [CNT_W-1:0]    free_count_q;
	logic [CNT_W-1:0]    next_fresh_q;

	logic                out_valid_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [IDX_W-1:0]    out_idx_q;
	logic [GEN_W-1:0]    out_gen_q;
	logic                out_live_q;

	logic [TBL_W-1:0]    tbl_rd;
	logic [TBL_W-1:0]    tbl_vis;
	logic [FQ_W-1:0]     fq_rd;
	logic [FQ_W-1:0]     fq_entry;
	logic [IDX_W-1:0]    fq_raddr;
	logic                idx_known;
	logic [GEN_W-1:0]    gen_vis;
	logic                live_vis;
	logic [GEN_W-1:0]    gen_inc;
	logic                handle_ok;

	logic                pop;
	logic                take_fresh;
	logic                push;
	logic                gen_we;
	logic [IDX_W-1:0]    gen_waddr;
	logic [TBL_W-1:0]    gen_wdata;
	logic [STATUS_W-1:0] res_status;
	logic [IDX_W-1:0]    res_idx;
	logic [GEN_W-1:0]    res_gen;
	logic                res_live;

	assign s_idx = s_tdata[IDX_W-1:0];
	assign s_gen = s_tdata[IDX_W+GEN_W-1:IDX_W];

	assign fire_s1 = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || fire_s1;
	assign s_accept = s_tvalid && s_tready;

	// state the command in s1 sees, with forwarding of a write made by the command ahead as it was accepted
	assign idx_known = (idx_s1 != '0) && ({1'b0, idx_s1} < next_fresh_q);
	assign tbl_vis = idx_known ? (gen_fwd_s1 ? gen_fwd_data_s1 : tbl_rd) : '0;
	assign gen_vis = tbl_vis[GEN_W-1:0];
	assign live_vis = tbl_vis[GEN_W];
	assign gen_inc = gen_vis + GEN_W'(1);
	assign fq_entry = fq_fwd_s1 ? fq_fwd_data_s1 : fq_rd;
	assign handle_ok = idx_known && live_vis && (gen_vis == gen_s1);

	always_comb begin
		pop = 1'b0;
		take_fresh = 1'b0;
		push = 1'b0;
		gen_we = 1'b0;
		gen_waddr = idx_s1;
		gen_wdata = {1'b0, gen_inc};
		res_status = ST_INVALID;
		res_idx = idx_s1;
		res_gen = gen_vis;
		res_live = 1'b0;
		case (cmd_s1)
			CMD_CREATE: begin
				if (free_count_q != '0) begin
					pop = 1'b1;
					gen_we = 1'b1;
					gen_waddr = fq_entry[IDX_W-1:0];
					gen_wdata = {1'b1, fq_entry[FQ_W-1:IDX_W]};
					res_status = ST_OK;
					res_idx = fq_entry[IDX_W-1:0];
					res_gen = fq_entry[FQ_W-1:IDX_W];
					res_live = 1'b1;
				end else if (next_fresh_q < CNT_W'(SLOTS)) begin
					take_fresh = 1'b1;
					gen_we = 1'b1;
					gen_waddr = next_fresh_q[IDX_W-1:0];
					gen_wdata = {1'b1, {GEN_W{1'b0}}};
					res_status = ST_OK;
					res_idx = next_fresh_q[IDX_W-1:0];
					res_gen = '0;
					res_live = 1'b1;
				end else begin
					res_status = ST_NO_SLOT;
					res_idx = '0;
					res_gen = '0;
				end
			end
			CMD_DESTROY: begin
				if (handle_ok && (free_count_q < CNT_W'(SLOTS))) begin
					push = 1'b1;
					gen_we = 1'b1;
					res_status = ST_OK;
					res_gen = gen_inc;
					res_live = 1'b1;
				end
			end
			CMD_CHECK: begin
				if (handle_ok) begin
					res_status = ST_OK;
					res_live = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign fq_raddr = (fire_s1 && pop) ? free_head_q + IDX_W'(1) : free_head_q;

	gha_ram #(
		.WIDTH(TBL_W),
		.DEPTH(SLOTS)
	) u_gen_table (
		.clk    (clk),
		.wr_en  (fire_s1 && gen_we),
		.wr_addr(gen_waddr),
		.wr_data(gen_wdata),
		.rd_en  (s_accept),
		.rd_addr(s_idx),
		.rd_data(tbl_rd)
	);

	gha_ram #(
		.WIDTH(FQ_W),
		.DEPTH(SLOTS)
	) u_free_queue (
		.clk    (clk),
		.wr_en  (fire_s1 && push),
		.wr_addr(free_tail_q),
		.wr_data({gen_inc, idx_s1}),
		.rd_en  (s_accept),
		.rd_addr(fq_raddr),
		.rd_data(fq_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_accept) begin
			valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			cmd_s1 <= s_tuser;
			idx_s1 <= s_idx;
			gen_s1 <= s_gen;
			gen_fwd_s1 <= fire_s1 && gen_we && (gen_waddr == s_idx);
			gen_fwd_data_s1 <= gen_wdata;
			fq_fwd_s1 <= fire_s1 && push && (fq_raddr == free_tail_q);
			fq_fwd_data_s1 <= {gen_inc, idx_s1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_head_q <= '0;
			free_tail_q <= '0;
			free_count_q <= '0;
			next_fresh_q <= CNT_W'(1);
		end else if (fire_s1) begin
			if (pop) begin
				free_head_q <= free_head_q + IDX_W'(1);
				free_count_q <= free_count_q - CNT_W'(1);
			end
			if (push) begin
				free_tail_q <= free_tail_q + IDX_W'(1);
				free_count_q <= free_count_q + CNT_W'(1);
			end
			if (take_fresh) begin
				next_fresh_q <= next_fresh_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			out_status_q <= res_status;
			out_idx_q <= res_idx;
			out_gen_q <= res_gen;
			out_live_q <= res_live;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = OUT_DATA_W'({out_gen_q, out_idx_q});
	assign m_tuser = {out_live_q, out_status_q};

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		free_count_q <= CNT_W'(SLOTS))
		else $error("free count out of range");

	a_fresh_range: assert property (@(posedge clk) disable iff (!arst_n)
		(next_fresh_q != '0) && (next_fresh_q <= CNT_W'(SLOTS)))
		else $error("fresh slot counter out of range");

	a_no_pop_push: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 |-> !(push && (pop || take_fresh)))
		else $error("destroy and create actions in one command");

	a_state_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!fire_s1 |=> $stable(free_count_q) && $stable(next_fresh_q)
			&& $stable(free_head_q) && $stable(free_tail_q))
		else $error("slot state changed without a command");

	a_live_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[STATUS_W]) |-> (m_tuser[STATUS_W-1:0] == ST_OK))
		else $error("live handle reported with failing status");

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
// testbench for generational_handle_allocator_core: directed and random create, destroy
// and check traffic, with results compared against an in-bench allocator predictor
// depends on gha_pkg and the allocator rtl
module tb;
	import gha_pkg::*;

	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int MAX_SHOWN = 20;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [IDX_W-1:0]    index;
		logic [GEN_W-1:0]    generation;
		logic                live;
	} alloc_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic [CMD_W-1:0]      s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [OUT_USER_W-1:0] m_tuser;

	// allocator state as predicted
	logic [GEN_W-1:0] slot_generation [SLOTS];
	logic             slot_taken [SLOTS];
	logic [IDX_W-1:0] recycled_slots [$];
	int               fresh_cursor;

	alloc_result_t expected_results [$];
	int            fail_count = 0;
	logic          src_gaps = 1'b0;
	logic          sink_stalls = 1'b0;

	generational_handle_allocator_core uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #6 clk = ~clk;

	task automatic log_mismatch(input string field, input int got, input int want);
		fail_count++;
		if (fail_count <= MAX_SHOWN) begin
			$display("%0t mismatch %s: got %0h want %0h", $realtime, field, got, want);
		end
	endtask

	task automatic model_command(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
			input logic [GEN_W-1:0] gen);
		alloc_result_t r;
		logic          handle_ok;
		logic [IDX_W-1:0] slot;
		r.status = ST_INVALID;
		r.index = idx;
		r.generation = slot_generation[idx];
		r.live = 1'b0;
		handle_ok = (idx != 0) && (int'(idx) < fresh_cursor) && slot_taken[idx]
			&& (slot_generation[idx] == gen);
		case (cmd)
			CMD_CREATE: begin
				if (recycled_slots.size() > 0 || fresh_cursor < SLOTS) begin
					if (recycled_slots.size() > 0) begin
						slot = recycled_slots.pop_front();
					end else begin
						slot = fresh_cursor[IDX_W-1:0];
						fresh_cursor++;
					end
					slot_taken[slot] = 1'b1;
					r.status = ST_OK;
					r.index = slot;
					r.generation = slot_generation[slot];
					r.live = 1'b1;
				end else begin
					r.status = ST_NO_SLOT;
					r.index = '0;
					r.generation = '0;
				end
			end
			CMD_DESTROY: begin
				if (handle_ok && recycled_slots.size() < SLOTS) begin
					slot_generation[idx] = slot_generation[idx] + 1'b1;
					slot_taken[idx] = 1'b0;
					recycled_slots = {recycled_slots, idx};
					r.status = ST_OK;
					r.generation = slot_generation[idx];
					r.live = 1'b1;
				end
			end
			CMD_CHECK: begin
				if (handle_ok) begin
					r.status = ST_OK;
					r.live = 1'b1;
				end
			end
			default: ;
		endcase
		expected_results = {expected_results, r};
	endtask

	task automatic issue_command(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
			input logic [GEN_W-1:0] gen);
		int gap;
		if (src_gaps && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 19);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {gen, idx};
		s_tuser <= cmd;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		model_command(cmd, idx, gen);
	endtask

	task automatic wait_results_drained();
		s_tvalid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
	endtask

	function automatic int pick_live_slot();
		int start;
		int s;
		start = $urandom_range(1, SLOTS - 1);
		for (int k = 0; k < SLOTS - 1; k++) begin
			s = 1 + (start - 1 + k) % (SLOTS - 1);
			if (slot_taken[s]) return s;
		end
		return 0;
	endfunction

	task automatic random_item();
		int r;
		int s;
		logic [IDX_W-1:0] idx;
		logic [GEN_W-1:0] gen;
		r = $urandom_range(0, 99);
		idx = IDX_W'($urandom_range(0, SLOTS - 1));
		gen = GEN_W'($urandom_range(0, 65535));
		s = pick_live_slot();
		if (r < 30) begin
			issue_command(CMD_CREATE, idx, gen);
		end else if (r < 60 && s != 0) begin
			issue_command(CMD_DESTROY, IDX_W'(s), slot_generation[s]);
		end else if (r < 72 && s != 0) begin
			issue_command(CMD_CHECK, IDX_W'(s), slot_generation[s]);
		end else if (r < 86) begin
			// stale handle: wrong generation, or a freed slot at its current generation
			s = $urandom_range(1, fresh_cursor > 1 ? fresh_cursor - 1 : 1);
			if (slot_taken[s] || $urandom_range(0, 1) == 0) begin
				gen = slot_generation[s] ^ GEN_W'($urandom_range(1, 65535));
			end else begin
				gen = slot_generation[s];
			end
			issue_command($urandom_range(0, 1) ? CMD_DESTROY : CMD_CHECK, IDX_W'(s), gen);
		end else if (r < 95) begin
			issue_command($urandom_range(0, 1) ? CMD_DESTROY : CMD_CHECK, idx, gen);
		end else begin
			issue_command(CMD_UNUSED, idx, gen);
		end
	endtask

	task automatic test_after_reset();
		issue_command(CMD_CHECK, 8'h00, 16'h0000);
		issue_command(CMD_DESTROY, 8'h00, 16'h0000);
		issue_command(CMD_CHECK, 8'h05, 16'h0000);
		issue_command(CMD_DESTROY, 8'hff, 16'hffff);
		issue_command(CMD_UNUSED, 8'haa, 16'h5555);
		wait_results_drained();
	endtask

	task automatic test_single_slot_life();
		issue_command(CMD_CREATE, 8'hff, 16'hffff);
		issue_command(CMD_CHECK, 8'h01, 16'h0000);
		issue_command(CMD_CHECK, 8'h01, 16'h0001);
		issue_command(CMD_UNUSED, 8'h01, 16'h0000);
		issue_command(CMD_DESTROY, 8'h01, 16'h0000);
		// freed slot is not live even at its new generation
		issue_command(CMD_DESTROY, 8'h01, 16'h0001);
		issue_command(CMD_CHECK, 8'h01, 16'h0001);
		issue_command(CMD_CREATE, 8'h00, 16'h0000);
		issue_command(CMD_CHECK, 8'h01, 16'h0001);
		issue_command(CMD_CHECK, 8'h02, 16'h0000);
		wait_results_drained();
	endtask

	task automatic test_fill_and_reuse();
		logic [GEN_W-1:0] old_gen;
		src_gaps = 1'b1;
		sink_stalls = 1'b1;
		while (fresh_cursor < SLOTS) issue_command(CMD_CREATE, 8'h00, 16'h0000);
		issue_command(CMD_CREATE, 8'h00, 16'h0000);
		issue_command(CMD_CREATE, 8'hff, 16'hffff);
		issue_command(CMD_CHECK, 8'hff, 16'h0000);
		issue_command(CMD_DESTROY, 8'hff, 16'hffff);
		old_gen = slot_generation[7];
		issue_command(CMD_DESTROY, 8'd7, slot_generation[7]);
		issue_command(CMD_DESTROY, 8'd3, slot_generation[3]);
		issue_command(CMD_DESTROY, 8'd200, slot_generation[200]);
		issue_command(CMD_CHECK, 8'd7, old_gen);
		// oldest freed slot comes back first
		repeat (3) issue_command(CMD_CREATE, 8'h00, 16'h0000);
		issue_command(CMD_CREATE, 8'h00, 16'h0000);
		wait_results_drained();
	endtask

	task automatic test_random_traffic(input int n);
		src_gaps = 1'b1;
		sink_stalls = 1'b1;
		for (int k = 0; k < n; k++) begin
			random_item();
			if (k == n / 2) wait_results_drained();
		end
	endtask

	task automatic test_back_to_back(input int n);
		src_gaps = 1'b0;
		sink_stalls = 1'b0;
		for (int k = 0; k < n; k++) random_item();
	endtask

	// result checker
	always @(posedge clk) begin : check_results
		alloc_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_results.size() == 0) begin
				log_mismatch("unexpected transaction index", int'(m_tdata[7:0]), 0);
			end else begin
				want = expected_results.pop_front();
				if (m_tuser[1:0] !== want.status)
					log_mismatch("status", int'(m_tuser[1:0]), int'(want.status));
				if (m_tdata[7:0] !== want.index)
					log_mismatch("result_index", int'(m_tdata[7:0]), int'(want.index));
				if (m_tdata[23:8] !== want.generation)
					log_mismatch("result_generation", int'(m_tdata[23:8]),
						int'(want.generation));
				if (m_tuser[2] !== want.live)
					log_mismatch("handle_live", int'(m_tuser[2]), int'(want.live));
			end
		end
	end

	// sink backpressure
	initial begin
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (sink_stalls && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	initial begin
		#12_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		for (int s = 0; s < SLOTS; s++) begin
			slot_generation[s] = '0;
			slot_taken[s] = 1'b0;
		end
		fresh_cursor = 1;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		src_gaps = 1'b1;
		sink_stalls = 1'b1;
		test_after_reset();
		test_single_slot_life();
		test_fill_and_reuse();
		test_random_traffic(620);
		test_back_to_back(150);
		wait_results_drained();
		repeat (16) @(posedge clk);
		if (fail_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
